// ===== rtl/ssid_pkg.sv =====
// Shared types and codes for the sorted set block.
// No dependencies; every other file takes names from here by scope or import.
package ssid_pkg;

  // Fixed field widths of the channel payloads.
  localparam int MODE_W  = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 3;
  localparam int POS_W   = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_DUMP   = 2'd2
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED   = 3'd0,
    STAT_DUPLICATE  = 3'd1,
    STAT_FULL       = 3'd2,
    STAT_REMOVED    = 3'd3,
    STAT_NOT_FOUND  = 3'd4,
    STAT_DUMP_ENTRY = 3'd5,
    STAT_EMPTY      = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    logic      occupied;
    logic      tail;
  } cell_ctrl_t;

endpackage

// ===== rtl/ssid_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on ssid_pkg for the payload widths.
interface ssid_in_if;
  logic                               valid;
  logic                               ready;
  logic        [ssid_pkg::MODE_W-1:0]  mode;
  logic signed [ssid_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface ssid_out_if;
  logic                               valid;
  logic                               ready;
  logic        [ssid_pkg::STAT_W-1:0]  status;
  logic signed [ssid_pkg::VALUE_W-1:0] entry_value;
  logic        [ssid_pkg::POS_W-1:0]   position;
  logic        [ssid_pkg::POS_W-1:0]   stored_count;
  logic                               last;

  modport source (output valid, output status, output entry_value, output position,
                  output stored_count, output last, input ready);
  modport sink   (input valid, input status, input entry_value, input position,
                  input stored_count, input last, output ready);
endinterface

// ===== rtl/ssid_cell.sv =====
// One slot of the sorted chain: holds a key, compares it with the operation key
// and takes its next key from itself, a neighbor, the head slot or the operation. Uses ssid_pkg.
module ssid_cell #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                   clk_i,
  input  ssid_pkg::cell_ctrl_t   ctrl_i,
  input  logic [KEY_WIDTH-1:0]   op_key_i,
  input  logic [KEY_WIDTH-1:0]   left_key_i,
  input  logic                   left_below_i,
  input  logic [KEY_WIDTH-1:0]   right_key_i,
  input  logic [KEY_WIDTH-1:0]   head_key_i,
  output logic [KEY_WIDTH-1:0]   key_o,
  output logic                   below_o,
  output logic                   equal_o
);

  logic [KEY_WIDTH-1:0] key_q, key_d;

  assign below_o = ctrl_i.occupied && ($signed(key_q) < $signed(op_key_i));
  assign equal_o = ctrl_i.occupied && (key_q == op_key_i);
  assign key_o   = key_q;

  always_comb begin
    key_d = key_q;
    case (ctrl_i.cmd)
      ssid_pkg::CELL_INSERT: begin
        // keep smaller keys, drop the new key at the boundary, shift the rest up
        if (!below_o) begin
          key_d = left_below_i ? op_key_i : left_key_i;
        end
      end
      ssid_pkg::CELL_DELETE: begin
        if (!below_o) begin
          key_d = right_key_i;
        end
      end
      ssid_pkg::CELL_ROTATE: begin
        // advance toward the head; the tail slot wraps the head key around
        key_d = ctrl_i.tail ? head_key_i : right_key_i;
      end
      default: key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

// ===== rtl/sorted_set_insert_delete.sv =====
// Top level of the sorted set: sequencer, chain of ssid_cell slots and output register.
// Depends on ssid_pkg, ssid_if (ssid_in_if, ssid_out_if) and ssid_cell.
//
//  channel  | dir | fields                                           | transfer
//  ---------+-----+--------------------------------------------------+-------------------
//  req_i    | in  | mode, value                                      | valid && ready
//  rsp_o    | out | status, entry_value, position, stored_count, last | valid && ready
//
// Insert and delete take the request in S_IDLE; in S_EXEC every slot then compares
// against the key and shifts in the same edge that loads the response.
// A dump goes from S_EXEC to S_DUMP, which loads one stored key per response; the
// chain rotates one slot per loaded response, so the head slot holds the next key to load.
// Reset clears the occupancy count, the sequencer and the response valid; slot contents stay undefined.
// A stalled response holds the sequencer in place; a new request is taken only in S_IDLE.
module sorted_set_insert_delete #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssid_in_if.sink           req_i,
  ssid_out_if.source        rsp_o
);

  localparam int IdxW   = $clog2(CAPACITY + 1);
  localparam int PosW   = ssid_pkg::POS_W;
  localparam int ValueW = ssid_pkg::VALUE_W;
  localparam int KeyW   = KEY_WIDTH;

  ssid_pkg::state_e state_q, state_d;

  logic [ssid_pkg::MODE_W-1:0] op_mode_q, op_mode_d;
  logic [KeyW-1:0]             op_key_q, op_key_d;
  logic [IdxW-1:0]             count_q, count_d;
  logic [IdxW-1:0]             dump_idx_q, dump_idx_d;

  logic                        out_valid_q, out_valid_d;
  logic [ssid_pkg::STAT_W-1:0] out_status_q, out_status_d;
  logic [ValueW-1:0]           out_value_q, out_value_d;
  logic [PosW-1:0]             out_pos_q, out_pos_d;
  logic [PosW-1:0]             out_count_q, out_count_d;
  logic                        out_last_q, out_last_d;
  logic                        out_free;
  logic                        out_load;

  ssid_pkg::cell_cmd_e         cmd;
  ssid_pkg::cell_ctrl_t        ctrl [CAPACITY];
  logic [KeyW-1:0]             cell_key [CAPACITY];
  logic [CAPACITY-1:0]         below;
  logic [CAPACITY-1:0]         equal;
  logic [CAPACITY:0]           below_ext;
  logic [IdxW-1:0]             ins_pos;
  logic                        found;

  // ---------------------------------------------------------------------------
  // chain of slots
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KeyW-1:0] left_key;
    logic            left_below;
    logic [KeyW-1:0] right_key;

    if (g == 0) begin : g_head
      assign left_key   = op_key_q;
      assign left_below = 1'b1;
    end else begin : g_mid
      assign left_key   = cell_key[g-1];
      assign left_below = below[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right_key = cell_key[g];
    end else begin : g_inner
      assign right_key = cell_key[g+1];
    end

    assign ctrl[g].cmd      = cmd;
    assign ctrl[g].occupied = (IdxW'(g) < count_q);
    assign ctrl[g].tail     = (IdxW'(g + 1) == count_q);

    ssid_cell #(
      .KEY_WIDTH (KeyW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[g]),
      .op_key_i     (op_key_q),
      .left_key_i   (left_key),
      .left_below_i (left_below),
      .right_key_i  (right_key),
      .head_key_i   (cell_key[0]),
      .key_o        (cell_key[g]),
      .below_o      (below[g]),
      .equal_o      (equal[g])
    );
  end

  // Ordered position: the one slot where "below" turns off, or the count if all are below.
  assign below_ext = {below, 1'b1};
  assign found     = |equal;

  always_comb begin
    ins_pos = '0;
    if (below[CAPACITY-1]) begin
      ins_pos = IdxW'(CAPACITY);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (below_ext[i] && !below_ext[i+1]) begin
        ins_pos = ins_pos | IdxW'(i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d      = state_q;
    op_mode_d    = op_mode_q;
    op_key_d     = op_key_q;
    count_d      = count_q;
    dump_idx_d   = dump_idx_q;
    cmd          = ssid_pkg::CELL_HOLD;
    out_load     = 1'b0;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_pos_d    = out_pos_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    req_i.ready  = 1'b0;

    case (state_q)
      ssid_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_mode_d = req_i.mode;
          op_key_d  = KeyW'($unsigned(req_i.value));
          state_d   = ssid_pkg::S_EXEC;
        end
      end

      ssid_pkg::S_EXEC: begin
        out_value_d = ValueW'(op_key_q);
        out_last_d  = 1'b1;
        case (op_mode_q)
          ssid_pkg::MODE_INSERT: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = ssid_pkg::S_IDLE;
              if (found) begin
                out_status_d = ssid_pkg::STAT_DUPLICATE;
                out_pos_d    = PosW'(ins_pos);
                out_count_d  = PosW'(count_q);
              end else if (count_q == IdxW'(CAPACITY)) begin
                out_status_d = ssid_pkg::STAT_FULL;
                out_pos_d    = '0;
                out_count_d  = PosW'(count_q);
              end else begin
                cmd          = ssid_pkg::CELL_INSERT;
                count_d      = count_q + 1'b1;
                out_status_d = ssid_pkg::STAT_INSERTED;
                out_pos_d    = PosW'(ins_pos);
                out_count_d  = PosW'(count_q + 1'b1);
              end
            end
          end
          ssid_pkg::MODE_DELETE: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = ssid_pkg::S_IDLE;
              if (found) begin
                cmd          = ssid_pkg::CELL_DELETE;
                count_d      = count_q - 1'b1;
                out_status_d = ssid_pkg::STAT_REMOVED;
                out_pos_d    = PosW'(ins_pos);
                out_count_d  = PosW'(count_q - 1'b1);
              end else begin
                out_status_d = ssid_pkg::STAT_NOT_FOUND;
                out_pos_d    = '0;
                out_count_d  = PosW'(count_q);
              end
            end
          end
          ssid_pkg::MODE_DUMP: begin
            if (count_q == '0) begin
              if (out_free) begin
                out_load     = 1'b1;
                out_status_d = ssid_pkg::STAT_EMPTY;
                out_value_d  = '0;
                out_pos_d    = '0;
                out_count_d  = '0;
                state_d      = ssid_pkg::S_IDLE;
              end
            end else begin
              dump_idx_d = '0;
              state_d    = ssid_pkg::S_DUMP;
            end
          end
          default: begin
            // unused mode: drop the request without a response
            state_d = ssid_pkg::S_IDLE;
          end
        endcase
      end

      ssid_pkg::S_DUMP: begin
        if (out_free) begin
          out_load     = 1'b1;
          cmd          = ssid_pkg::CELL_ROTATE;
          out_status_d = ssid_pkg::STAT_DUMP_ENTRY;
          out_value_d  = ValueW'(cell_key[0]);
          out_pos_d    = PosW'(dump_idx_q);
          out_count_d  = PosW'(count_q);
          out_last_d   = (dump_idx_q + 1'b1 == count_q);
          dump_idx_d   = dump_idx_q + 1'b1;
          if (dump_idx_q + 1'b1 == count_q) begin
            state_d = ssid_pkg::S_IDLE;
          end
        end
      end

      default: state_d = ssid_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssid_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_mode_q    <= op_mode_d;
    op_key_q     <= op_key_d;
    dump_idx_q   <= dump_idx_d;
    // hold the waiting response until a new one is loaded
    if (out_load) begin
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_pos_q    <= out_pos_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.entry_value  = out_value_q;
  assign rsp_o.position     = out_pos_q;
  assign rsp_o.stored_count = out_count_q;
  assign rsp_o.last         = out_last_q;

endmodule

// ===== tb/sorted_set_insert_delete_test.sv =====
// Self-checking testbench for sorted_set_insert_delete: inserts, deletes and dumps
// with random idling on both channels, checked against a scoreboard that tracks the set.
// Depends on ssid_pkg, ssid_in_if, ssid_out_if and the sorted_set_insert_delete RTL.
module sorted_set_insert_delete_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssid_pkg::*;

  localparam int SET_CAPACITY = 16;
  localparam int POOL_SIZE = 24;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  class set_scoreboard;
    typedef struct {
      status_e               status;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]      position;
      logic [POS_W-1:0]      stored;
      logic                  last;
    } response_t;

    response_t pending_responses[$];
    logic signed [VALUE_W-1:0] keys[SET_CAPACITY];
    int key_count;
    int errors;
    int checked;
    int peak_count;
    int full_hits;
    int mode_hits[4];

    function void add_response(status_e st, logic signed [VALUE_W-1:0] v, int pos, bit lst);
      response_t r;
      r.status   = st;
      r.value    = v;
      r.position = POS_W'(pos);
      r.stored   = POS_W'(key_count);
      r.last     = lst;
      pending_responses.push_back(r);
    endfunction

    // Update the set for one accepted request and queue the responses it causes.
    function void apply_request(logic [MODE_W-1:0] mode_bits, logic signed [VALUE_W-1:0] key);
      int idx;
      bit hit;
      mode_hits[mode_bits]++;
      if (mode_bits == MODE_DUMP) begin
        if (key_count == 0) add_response(STAT_EMPTY, '0, 0, 1'b1);
        for (int i = 0; i < key_count; i++)
          add_response(STAT_DUMP_ENTRY, keys[i], i, i == key_count - 1);
      end else if (mode_bits == MODE_INSERT || mode_bits == MODE_DELETE) begin
        idx = 0;
        while (idx < key_count && keys[idx] < key) idx++;
        hit = idx < key_count && keys[idx] == key;
        if (mode_bits == MODE_INSERT) begin
          if (hit) begin
            add_response(STAT_DUPLICATE, key, idx, 1'b1);
          end else if (key_count >= SET_CAPACITY) begin
            full_hits++;
            add_response(STAT_FULL, key, 0, 1'b1);
          end else begin
            for (int i = key_count; i > idx; i--) keys[i] = keys[i-1];
            keys[idx] = key;
            key_count++;
            if (key_count > peak_count) peak_count = key_count;
            add_response(STAT_INSERTED, key, idx, 1'b1);
          end
        end else if (hit) begin
          for (int i = idx; i + 1 < key_count; i++) keys[i] = keys[i+1];
          key_count--;
          add_response(STAT_REMOVED, key, idx, 1'b1);
        end else begin
          add_response(STAT_NOT_FOUND, key, 0, 1'b1);
        end
      end
    endfunction

    function void check_response(logic [STAT_W-1:0] st, logic signed [VALUE_W-1:0] v,
                                 logic [POS_W-1:0] pos, logic [POS_W-1:0] cnt, logic lst);
      response_t r;
      checked++;
      if (pending_responses.size() == 0) begin
        errors++;
        $display("%0t: response with none expected: status %0d value %0d position %0d",
                 $time, st, v, pos);
        return;
      end
      r = pending_responses.pop_front();
      if (st !== r.status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, r.status, st);
      end
      if (v !== r.value) begin
        errors++;
        $display("%0t: entry_value expected %0d, got %0d", $time, r.value, v);
      end
      if (pos !== r.position) begin
        errors++;
        $display("%0t: position expected %0d, got %0d", $time, r.position, pos);
      end
      if (cnt !== r.stored) begin
        errors++;
        $display("%0t: stored_count expected %0d, got %0d", $time, r.stored, cnt);
      end
      if (lst !== r.last) begin
        errors++;
        $display("%0t: last expected %0d, got %0d", $time, r.last, lst);
      end
    endfunction

    function int pending();
      return pending_responses.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit hold_off_go;
  bit hold_off_done;
  set_scoreboard sb;

  ssid_in_if  req_if ();
  ssid_out_if rsp_if ();

  sorted_set_insert_delete dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int idle_cycles();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Call right after a rising edge; returns right after the transfer edge.
  task automatic send_request(input logic [MODE_W-1:0] m, input logic signed [VALUE_W-1:0] v);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= m;
    req_if.value <= v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.apply_request(m, v);
  endtask

  task automatic wait_all_responses();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_response(rsp_if.status, rsp_if.entry_value, rsp_if.position,
                        rsp_if.stored_count, rsp_if.last);
  end

  // Response side: random back-pressure, plus one long hold-off on request.
  initial begin
    int gap;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_go && !hold_off_done) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(0, 9) == 0 ? 80 : $urandom_range(1, 6)) @(posedge clk_i);
        gap = idle_cycles();
        if (gap > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic signed [VALUE_W-1:0] key_pool[POOL_SIZE];
    logic signed [VALUE_W-1:0] key;
    logic [MODE_W-1:0] m;
    int sent;
    int pick;
    int ins_pct;
    int del_pct;

    sb = new();
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.mode  <= MODE_INSERT;
    req_if.value <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty set, extremes, duplicates, misses, full set.
    send_request(MODE_DUMP, 32'sd77);
    send_request(MODE_DELETE, 32'sd5);
    send_request(MODE_UNUSED, $urandom());
    send_request(MODE_INSERT, 32'sd0);
    send_request(MODE_INSERT, 32'sh7FFF_FFFF);
    send_request(MODE_INSERT, 32'sh8000_0000);
    send_request(MODE_INSERT, -32'sd1);
    send_request(MODE_INSERT, 32'sd1);
    send_request(MODE_INSERT, 32'sd0);
    send_request(MODE_DELETE, 32'sd5);
    send_request(MODE_DELETE, 32'sh7FFF_FFFF);
    for (int i = 0; i < 12; i++) begin
      key = (i + 2) * 32'sh0100_0001;
      send_request(MODE_INSERT, (i % 2) ? -key : key);
    end
    send_request(MODE_INSERT, 32'sd7);
    send_request(MODE_INSERT, 32'sd1);
    send_request(MODE_DUMP, '0);
    send_request(MODE_DELETE, 32'sh8000_0000);

    // Random: fill-heavy, balanced, then drain-heavy phases over a small key pool.
    hold_off_go = 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      if (phase > 0) wait_all_responses();
      foreach (key_pool[i])
        key_pool[i] = (i == 0) ? 32'sh8000_0000 : (i == 1) ? 32'sh7FFF_FFFF :
                      (i == 2) ? 32'sd0 : (i == 3) ? -32'sd1 : $urandom();
      ins_pct = (phase == 0) ? 60 : (phase == 1) ? 42 : 28;
      del_pct = (phase == 0) ? 22 : (phase == 1) ? 40 : 54;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        m = (pick < ins_pct) ? MODE_INSERT :
            (pick < ins_pct + del_pct) ? MODE_DELETE :
            (pick < ins_pct + del_pct + 14) ? MODE_DUMP : MODE_UNUSED;
        key = ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, POOL_SIZE-1)];
        send_request(m, key);
        if (m != MODE_UNUSED) sent++;
      end
    end

    wait_all_responses();
    $display("Sent %0d inserts, %0d deletes, %0d dumps, %0d unused; checked %0d responses.",
             sb.mode_hits[MODE_INSERT], sb.mode_hits[MODE_DELETE], sb.mode_hits[MODE_DUMP],
             sb.mode_hits[MODE_UNUSED], sb.checked);
    $display("Set peaked at %0d keys; %0d inserts hit a full set.", sb.peak_count, sb.full_hits);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ssid_pkg.sv
rtl/ssid_if.sv
rtl/ssid_cell.sv
rtl/sorted_set_insert_delete.sv
tb/sorted_set_insert_delete_test.sv
